// ===== rtl/sps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sps_pkg;

  localparam int unsigned STATE_W    = 3;
  localparam int unsigned TXN_W      = 3;
  localparam int unsigned ERR_W      = 2;
  localparam int unsigned TIME_W     = 16;
  localparam int unsigned RX_W       = 48;
  localparam int unsigned RAW20_W    = 20;
  localparam int unsigned PAW_W      = 14;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // sequencer state codes
  localparam logic [STATE_W-1:0] ST_STOPPED   = 3'd0;
  localparam logic [STATE_W-1:0] ST_REQ_FLOW  = 3'd2;
  localparam logic [STATE_W-1:0] ST_READ_FLOW = 3'd3;
  localparam logic [STATE_W-1:0] ST_READ_PAW  = 3'd4;
  localparam logic [STATE_W-1:0] ST_BARO_ADDR = 3'd5;
  localparam logic [STATE_W-1:0] ST_BARO_READ = 3'd6;

  // next bus transfer codes
  localparam logic [TXN_W-1:0] TXN_NONE      = 3'd0;
  localparam logic [TXN_W-1:0] TXN_FLOW_REQ  = 3'd1;
  localparam logic [TXN_W-1:0] TXN_FLOW_READ = 3'd2;
  localparam logic [TXN_W-1:0] TXN_PAW_READ  = 3'd3;
  localparam logic [TXN_W-1:0] TXN_BARO_ADDR = 3'd4;
  localparam logic [TXN_W-1:0] TXN_BARO_READ = 3'd5;

  // command and bus error codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DONE  = 1'b1;
  localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
  localparam logic [ERR_W-1:0] ERR_NACK = 2'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAW_MIN_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BARO_PERIOD_MASK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_RAW_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_RAW_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_RAW_MIN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_RAW_MAX     = 3'd5;

  // reset values
  localparam logic [TIME_W-1:0]  PAW_MIN_RESET   = 16'd4700;
  localparam logic [TIME_W-1:0]  BARO_MASK_RESET = 16'h0FFF;
  localparam logic [TIME_W-1:0]  BARO_CNT_RESET  = 16'h0FFF;
  localparam logic [RAW20_W-1:0] RAW_MIN_RESET   = 20'd0;
  localparam logic [RAW20_W-1:0] RAW_MAX_RESET   = 20'd1048560;

  // flow sensor answers all-ones in its first three bytes when it has no data
  localparam logic [23:0] FLOW_EMPTY = 24'hFFFFFF;

  typedef struct packed {
    logic              cmd;
    logic [ERR_W-1:0]  bus_error;
    logic [RX_W-1:0]   rx_data;
    logic [TIME_W-1:0] time_now;
  } in_t;

  typedef struct packed {
    logic [TXN_W-1:0]   next_txn;
    logic               flow_valid;
    logic signed [15:0] flow_value;
    logic [TIME_W-1:0]  flow_dt;
    logic               paw_valid;
    logic [PAW_W-1:0]   paw_raw;
    logic [TIME_W-1:0]  paw_dt;
    logic               press_valid;
    logic [RAW20_W-1:0] press_raw;
    logic               temp_valid;
    logic [RAW20_W-1:0] temp_raw;
  } out_t;

  typedef struct packed {
    logic [TIME_W-1:0]  paw_min_interval;
    logic [TIME_W-1:0]  baro_period_mask;
    logic [RAW20_W-1:0] press_raw_min;
    logic [RAW20_W-1:0] press_raw_max;
    logic [RAW20_W-1:0] temp_raw_min;
    logic [RAW20_W-1:0] temp_raw_max;
  } cfg_t;

  typedef struct packed {
    logic [STATE_W-1:0] state;
    logic [TIME_W-1:0]  last_flow_time;
    logic [TIME_W-1:0]  last_paw_time;
    logic [TIME_W-1:0]  baro_counter;
  } seq_t;

endpackage
`default_nettype wire

// ===== rtl/sps_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sps_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [sps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sps_pkg::CFG_DATA_W-1:0]   cfg_data,
  output sps_pkg::cfg_t                         cfg
);
  import sps_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.paw_min_interval <= PAW_MIN_RESET;
      cfg.baro_period_mask <= BARO_MASK_RESET;
      cfg.press_raw_min    <= RAW_MIN_RESET;
      cfg.press_raw_max    <= RAW_MAX_RESET;
      cfg.temp_raw_min     <= RAW_MIN_RESET;
      cfg.temp_raw_max     <= RAW_MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAW_MIN_INTERVAL: cfg.paw_min_interval <= cfg_data[TIME_W-1:0];
        CFG_BARO_PERIOD_MASK: cfg.baro_period_mask <= cfg_data[TIME_W-1:0];
        CFG_PRESS_RAW_MIN:    cfg.press_raw_min    <= cfg_data[RAW20_W-1:0];
        CFG_PRESS_RAW_MAX:    cfg.press_raw_max    <= cfg_data[RAW20_W-1:0];
        CFG_TEMP_RAW_MIN:     cfg.temp_raw_min     <= cfg_data[RAW20_W-1:0];
        CFG_TEMP_RAW_MAX:     cfg.temp_raw_max     <= cfg_data[RAW20_W-1:0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sps_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sps_step (
  input  wire sps_pkg::in_t  item,
  input  wire sps_pkg::seq_t seq,
  input  wire sps_pkg::cfg_t cfg,
  output sps_pkg::seq_t      seq_next,
  output sps_pkg::out_t      res
);
  import sps_pkg::*;

  logic [TIME_W-1:0]  flow_dt;
  logic [TIME_W-1:0]  paw_dt;
  logic [RAW20_W-1:0] press;
  logic [RAW20_W-1:0] temp;
  logic               flow_empty;
  logic               baro_due;
  logic               nack;
  logic               fatal;

  // flow delta is one short of the modular difference when the timer wrapped
  assign flow_dt = item.time_now - seq.last_flow_time -
                   {{(TIME_W-1){1'b0}}, (item.time_now < seq.last_flow_time)};
  assign paw_dt     = item.time_now - seq.last_paw_time;
  assign press      = item.rx_data[47:28];
  assign temp       = item.rx_data[23:4];
  assign flow_empty = (item.rx_data[47:24] == FLOW_EMPTY);
  assign baro_due   = ((seq.baro_counter & cfg.baro_period_mask) == cfg.baro_period_mask);
  assign nack       = (item.bus_error == ERR_NACK);
  assign fatal      = !(item.bus_error inside {ERR_NONE, ERR_NACK});

  always_comb begin
    seq_next = seq;
    res      = '0;
    if (item.cmd == CMD_START) begin
      seq_next.state = ST_REQ_FLOW;
      res.next_txn   = TXN_FLOW_REQ;
    end else begin
      case (seq.state)
        ST_REQ_FLOW: begin
          if (nack) begin
            res.next_txn = TXN_FLOW_REQ;
          end else if (fatal) begin
            seq_next.state = ST_STOPPED;
          end else begin
            seq_next.state = ST_READ_FLOW;
            res.next_txn   = TXN_FLOW_READ;
          end
        end
        ST_READ_FLOW: begin
          if (nack) begin
            seq_next.state = ST_READ_PAW;
            res.next_txn   = TXN_PAW_READ;
          end else if (fatal) begin
            seq_next.state = ST_STOPPED;
          end else if (!flow_empty) begin
            res.flow_valid          = 1'b1;
            res.flow_value          = $signed(item.rx_data[47:32]);
            res.flow_dt             = flow_dt;
            seq_next.last_flow_time = item.time_now;
            res.next_txn            = TXN_FLOW_READ;
          end else begin
            seq_next.baro_counter = seq.baro_counter + 16'd1;
            if (baro_due) begin
              seq_next.state = ST_BARO_ADDR;
              res.next_txn   = TXN_BARO_ADDR;
            end else begin
              seq_next.state = ST_READ_PAW;
              res.next_txn   = TXN_PAW_READ;
            end
          end
        end
        ST_READ_PAW: begin
          if (nack) begin
            res.next_txn = TXN_PAW_READ;
          end else if (fatal) begin
            seq_next.state = ST_STOPPED;
          end else begin
            // status bits must be clear and the sample not too close to the last
            if (item.rx_data[47:46] == 2'b00 && paw_dt > cfg.paw_min_interval) begin
              res.paw_valid          = 1'b1;
              res.paw_raw            = item.rx_data[45:32];
              res.paw_dt             = paw_dt;
              seq_next.last_paw_time = item.time_now;
            end
            seq_next.state = ST_READ_FLOW;
            res.next_txn   = TXN_FLOW_READ;
          end
        end
        ST_BARO_ADDR: begin
          seq_next.state = ST_BARO_READ;
          res.next_txn   = TXN_BARO_READ;
        end
        ST_BARO_READ: begin
          if (press > cfg.press_raw_min && press < cfg.press_raw_max) begin
            res.press_valid = 1'b1;
            res.press_raw   = press;
          end
          if (temp > cfg.temp_raw_min && temp < cfg.temp_raw_max) begin
            res.temp_valid = 1'b1;
            res.temp_raw   = temp;
          end
          seq_next.state = ST_READ_PAW;
          res.next_txn   = TXN_PAW_READ;
        end
        default: begin
          seq_next.state = ST_STOPPED;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sensor_poll_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   signals                          payload         direction
// item      item_valid / item_stall          item (in_t)     in
// result    result_valid / result_stall      result (out_t)  out
// config    cfg_we / cfg_index / cfg_data    register write  in
//
// one transaction per clock sustained while result_stall stays low; each item gives exactly one result
// each item passes the input register, then the step logic into the result register
// the step logic is a single pass, and the sequencer state updates with the result
// rst is synchronous: state stopped, both sample times zero, barometer counter 0x0fff
// a stalled result holds the input register; item_stall rises only when both are full
module sensor_poll_sequencer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            item_valid,
  output logic                                 item_stall,
  input  wire sps_pkg::in_t                    item,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output sps_pkg::out_t                        result,
  input  wire logic                            cfg_we,
  input  wire logic [sps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sps_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sps_pkg::*;

  cfg_t  cfg;
  in_t   stage;
  logic  stage_valid;
  seq_t  seq;
  seq_t  seq_next;
  out_t  result_next;
  logic  advance;
  logic  accept;

  // configuration registers
  sps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // step logic: one transaction from the input register into the result register
  sps_step u_step (
    .item     (stage),
    .seq      (seq),
    .cfg      (cfg),
    .seq_next (seq_next),
    .res      (result_next)
  );

  // the input register moves on whenever the result register is free or draining
  assign advance    = stage_valid && (!result_valid || !result_stall);
  assign item_stall = stage_valid && !advance;
  assign accept     = item_valid && !item_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= item;
    end
  end

  // sequencer state, updated together with the result it produced
  always_ff @(posedge clk) begin
    if (rst) begin
      seq.state          <= ST_STOPPED;
      seq.last_flow_time <= '0;
      seq.last_paw_time  <= '0;
      seq.baro_counter   <= BARO_CNT_RESET;
    end else if (advance) begin
      seq <= seq_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  // a start command always leaves the sequencer requesting flow
  a_start_restarts: assert property (@(posedge clk) disable iff (rst)
    advance && stage.cmd == CMD_START |=> seq.state == ST_REQ_FLOW)
    else $error("start command did not restart the sequence");

  // a flow sample is only ever followed by another flow read
  a_flow_then_read: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.flow_valid |-> result.next_txn == TXN_FLOW_READ)
    else $error("flow sample without a following flow read");

  // barometer samples come only from the barometer read, which leads to a paw read
  a_baro_then_paw: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.press_valid || result.temp_valid)
      |-> result.next_txn == TXN_PAW_READ)
    else $error("barometer sample outside the barometer read");

  // input side stalls only when a transaction waits in the input register
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> stage_valid && result_valid)
    else $error("input stalled with an empty pipeline");

  // value fields are zero when their sample is absent
  a_empty_fields_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.flow_valid |-> result.flow_value == 0 && result.flow_dt == 0)
    else $error("flow fields set without a flow sample");

endmodule
`default_nettype wire

// ===== tb/sensor_poll_sequencer_tb.sv =====
`timescale 1ns / 1ps
module sensor_poll_sequencer_tb;
  import sps_pkg::*;

  // generous cycle budget: ~1700 transactions with random idling on both sides
  localparam int unsigned LIMIT = 200000;
  localparam int unsigned PRINT_CAP = 50;

  // predicts the sequencer and holds the results still owed by the block
  class poll_scoreboard;
    cfg_t regs;
    logic [STATE_W-1:0] state;
    logic [TIME_W-1:0] flow_stamp;
    logic [TIME_W-1:0] paw_stamp;
    logic [TIME_W-1:0] baro_count;
    out_t awaited[$];
    int unsigned errors;

    function new();
      regs.paw_min_interval = PAW_MIN_RESET;
      regs.baro_period_mask = BARO_MASK_RESET;
      regs.press_raw_min = RAW_MIN_RESET;
      regs.press_raw_max = RAW_MAX_RESET;
      regs.temp_raw_min = RAW_MIN_RESET;
      regs.temp_raw_max = RAW_MAX_RESET;
      state = ST_STOPPED;
      flow_stamp = '0;
      paw_stamp = '0;
      baro_count = BARO_CNT_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PAW_MIN_INTERVAL: regs.paw_min_interval = data[TIME_W-1:0];
        CFG_BARO_PERIOD_MASK: regs.baro_period_mask = data[TIME_W-1:0];
        CFG_PRESS_RAW_MIN:    regs.press_raw_min = data;
        CFG_PRESS_RAW_MAX:    regs.press_raw_max = data;
        CFG_TEMP_RAW_MIN:     regs.temp_raw_min = data;
        CFG_TEMP_RAW_MAX:     regs.temp_raw_max = data;
        default: ;
      endcase
    endfunction

    // advance the predicted sequencer by one transaction, queue its result
    function void step_sequencer(in_t it);
      out_t r;
      logic [7:0] b0, b1, b2, b3, b4, b5;
      logic [TIME_W-1:0] dt;
      logic [RAW20_W-1:0] p, t;
      logic baro_due;
      r = '0;
      {b0, b1, b2, b3, b4, b5} = it.rx_data;
      if (it.cmd == CMD_START) begin
        state = ST_REQ_FLOW;
        r.next_txn = TXN_FLOW_REQ;
      end else begin
        case (state)
          ST_REQ_FLOW: begin
            if (it.bus_error == ERR_NACK) begin
              r.next_txn = TXN_FLOW_REQ;
            end else if (it.bus_error != ERR_NONE) begin
              state = ST_STOPPED;
            end else begin
              state = ST_READ_FLOW;
              r.next_txn = TXN_FLOW_READ;
            end
          end
          ST_READ_FLOW: begin
            if (it.bus_error == ERR_NACK) begin
              state = ST_READ_PAW;
              r.next_txn = TXN_PAW_READ;
            end else if (it.bus_error != ERR_NONE) begin
              state = ST_STOPPED;
            end else if ({b0, b1, b2} != FLOW_EMPTY) begin
              // on timer wrap the delta comes out one short of the modular difference
              if (it.time_now < flow_stamp) dt = it.time_now + 16'hFFFF - flow_stamp;
              else dt = it.time_now - flow_stamp;
              r.flow_valid = 1'b1;
              r.flow_value = {b0, b1};
              r.flow_dt = dt;
              flow_stamp = it.time_now;
              r.next_txn = TXN_FLOW_READ;
            end else begin
              baro_due = (baro_count & regs.baro_period_mask) == regs.baro_period_mask;
              baro_count = baro_count + 16'd1;
              if (baro_due) begin
                state = ST_BARO_ADDR;
                r.next_txn = TXN_BARO_ADDR;
              end else begin
                state = ST_READ_PAW;
                r.next_txn = TXN_PAW_READ;
              end
            end
          end
          ST_READ_PAW: begin
            if (it.bus_error == ERR_NACK) begin
              r.next_txn = TXN_PAW_READ;
            end else if (it.bus_error != ERR_NONE) begin
              state = ST_STOPPED;
            end else begin
              dt = it.time_now - paw_stamp;
              if (b0[7:6] == 2'b00 && dt > regs.paw_min_interval) begin
                r.paw_valid = 1'b1;
                r.paw_raw = {b0[5:0], b1};
                r.paw_dt = dt;
                paw_stamp = it.time_now;
              end
              state = ST_READ_FLOW;
              r.next_txn = TXN_FLOW_READ;
            end
          end
          ST_BARO_ADDR: begin
            state = ST_BARO_READ;
            r.next_txn = TXN_BARO_READ;
          end
          ST_BARO_READ: begin
            p = {b0, b1, b2[7:4]};
            t = {b3, b4, b5[7:4]};
            if (p > regs.press_raw_min && p < regs.press_raw_max) begin
              r.press_valid = 1'b1;
              r.press_raw = p;
            end
            if (t > regs.temp_raw_min && t < regs.temp_raw_max) begin
              r.temp_valid = 1'b1;
              r.temp_raw = t;
            end
            state = ST_READ_PAW;
            r.next_txn = TXN_PAW_READ;
          end
          default: state = ST_STOPPED;
        endcase
      end
      awaited.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_result(out_t got);
      out_t want;
      if (awaited.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        want = awaited.pop_front();
        check_field("next_txn", got.next_txn, want.next_txn);
        check_field("flow_valid", got.flow_valid, want.flow_valid);
        check_field("flow_value", got.flow_value, want.flow_value);
        check_field("flow_dt", got.flow_dt, want.flow_dt);
        check_field("paw_valid", got.paw_valid, want.paw_valid);
        check_field("paw_raw", got.paw_raw, want.paw_raw);
        check_field("paw_dt", got.paw_dt, want.paw_dt);
        check_field("press_valid", got.press_valid, want.press_valid);
        check_field("press_raw", got.press_raw, want.press_raw);
        check_field("temp_valid", got.temp_valid, want.temp_valid);
        check_field("temp_raw", got.temp_raw, want.temp_raw);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  in_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  out_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  poll_scoreboard sb = new();

  // idle percentages for each side, changed per phase
  int unsigned send_idle = 35;
  int unsigned recv_idle = 70;
  int unsigned cycles = 0;
  // microsecond timer stepped by each random transaction and seen by most of them
  logic [TIME_W-1:0] us_clock = '0;

  sensor_poll_sequencer DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stall, check every accepted transaction
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
    result_stall <= !rst && ($urandom_range(0, 99) < recv_idle);
  end

  function automatic in_t item_of(logic cmd, logic [ERR_W-1:0] err, logic [RX_W-1:0] rx,
                                  logic [TIME_W-1:0] now);
    in_t it;
    it.cmd = cmd;
    it.bus_error = err;
    it.rx_data = rx;
    it.time_now = now;
    return it;
  endfunction

  // pick a raw value on or next to the edges of its valid window, or anywhere
  function automatic logic [RAW20_W-1:0] near_edge(logic [RAW20_W-1:0] lo,
                                                   logic [RAW20_W-1:0] hi);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return lo + 20'd1;
      2: return hi;
      3: return hi - 20'd1;
      default: return RAW20_W'($urandom);
    endcase
  endfunction

  // random transaction shaped by where the predicted sequencer stands:
  // mostly the completion the sequencer waits for, with some errors and restarts
  function automatic in_t random_item();
    in_t it;
    int unsigned roll;
    int unsigned err_roll;
    us_clock = us_clock + 16'($urandom_range(0, 2500));
    it.cmd = CMD_DONE;
    it.bus_error = ERR_NONE;
    it.rx_data = {16'($urandom), $urandom};
    it.time_now = ($urandom_range(0, 9) == 0) ? 16'($urandom) : us_clock;
    roll = $urandom_range(0, 99);
    err_roll = $urandom_range(0, 99);
    if (sb.state == ST_STOPPED) begin
      // mostly restart; a stray completion is ignored while stopped
      if (roll < 80) it.cmd = CMD_START;
      else it.bus_error = ERR_W'($urandom_range(0, 3));
    end else if (roll < 3) begin
      it.cmd = CMD_START;
      it.bus_error = ERR_W'($urandom_range(0, 3));
    end else begin
      if (err_roll < 10) it.bus_error = ERR_NACK;
      else if (err_roll < 12) it.bus_error = {1'b1, 1'($urandom)};
      case (sb.state)
        ST_READ_FLOW: begin
          // all-ones means no flow data; near misses still decode
          if (roll < 38) it.rx_data[47:24] = FLOW_EMPTY;
          else if (roll < 43) it.rx_data[47:24] = FLOW_EMPTY ^ (24'd1 << $urandom_range(0, 23));
        end
        ST_READ_PAW: begin
          if (roll < 78) it.rx_data[47:46] = 2'b00;
        end
        ST_BARO_READ: begin
          it.rx_data[47:28] = near_edge(sb.regs.press_raw_min, sb.regs.press_raw_max);
          it.rx_data[23:4] = near_edge(sb.regs.temp_raw_min, sb.regs.temp_raw_max);
        end
        default: ;
      endcase
    end
    return it;
  endfunction

  // present one transaction, wait for acceptance, then idle at random
  task automatic issue(in_t it);
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    sb.step_sequencer(it);
    while ($urandom_range(0, 99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain();
    item_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // write all six registers back to back; only called while the block is idle
  task automatic load_settings(cfg_t c);
    put_reg(CFG_PAW_MIN_INTERVAL, CFG_DATA_W'(c.paw_min_interval));
    put_reg(CFG_BARO_PERIOD_MASK, CFG_DATA_W'(c.baro_period_mask));
    put_reg(CFG_PRESS_RAW_MIN, c.press_raw_min);
    put_reg(CFG_PRESS_RAW_MAX, c.press_raw_max);
    put_reg(CFG_TEMP_RAW_MIN, c.temp_raw_min);
    put_reg(CFG_TEMP_RAW_MAX, c.temp_raw_max);
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t settings_for(int unsigned blk);
    cfg_t c;
    case (blk)
      0: c = '{16'd0, 16'd0, 20'd0, 20'hFFFFF, 20'd0, 20'hFFFFF};          // everything open
      2: c = '{16'hFFFF, 16'hFFFF, 20'hFFFFF, 20'd0, 20'hFFFFF, 20'd0};    // everything shut
      4: c = '{PAW_MIN_RESET, 16'd3, RAW_MIN_RESET, RAW_MAX_RESET, RAW_MIN_RESET, RAW_MAX_RESET};
      default: begin
        c.paw_min_interval = 16'($urandom_range(0, 6000));
        c.baro_period_mask = 16'((1 << $urandom_range(0, 4)) - 1);
        c.press_raw_min = 20'($urandom_range(0, 20'h7FFFF));
        c.press_raw_max = 20'($urandom_range(20'h80000, 20'hFFFFF));
        c.temp_raw_min = 20'($urandom_range(0, 20'h7FFFF));
        c.temp_raw_max = 20'($urandom_range(20'h80000, 20'hFFFFF));
      end
    endcase
    return c;
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed pass under reset settings
    issue(item_of(CMD_DONE, ERR_NONE, 48'h0, 16'd10));                 // completion while stopped
    issue(item_of(CMD_START, 2'd3, 48'hFFFF_FFFF_FFFF, 16'hFFFF));     // start ignores other fields
    issue(item_of(CMD_DONE, ERR_NACK, 48'h0, 16'd20));                 // flow request resent
    issue(item_of(CMD_DONE, ERR_NONE, 48'h0, 16'd30));
    issue(item_of(CMD_DONE, ERR_NONE, 48'h7FFF_00_123456, 16'd100));   // max positive flow
    issue(item_of(CMD_DONE, ERR_NONE, 48'h8000_FF_000000, 16'd50));    // most negative, timer wrap
    issue(item_of(CMD_DONE, ERR_NONE, 48'hFFFF_FE_FFFFFF, 16'd50));    // near all-ones, zero delta
    issue(item_of(CMD_DONE, ERR_NONE, 48'hFFFF_FF_000000, 16'd60));    // no data, barometer due
    issue(item_of(CMD_DONE, 2'd2, 48'h0, 16'd70));                     // error ignored in baro stage
    issue(item_of(CMD_DONE, 2'd3, {20'hFFFFF, 4'h0, 20'h00001, 4'hA}, 16'd80));
    issue(item_of(CMD_DONE, ERR_NACK, 48'h0, 16'd90));                 // pressure read retried
    issue(item_of(CMD_DONE, ERR_NONE, 48'h4123_000000_00, 16'd5000));  // status bits set, no sample
    issue(item_of(CMD_DONE, ERR_NACK, 48'h0, 16'd5000));               // failed flow read skips ahead
    issue(item_of(CMD_DONE, ERR_NONE, 48'h3FFF_00000000, 16'd5000));   // largest pressure reading
    issue(item_of(CMD_DONE, ERR_NONE, 48'hFFFFFF_000000, 16'd9000));   // no data, no barometer
    issue(item_of(CMD_DONE, ERR_NONE, 48'h0000_00000000, 16'd9700));   // delta equals minimum
    issue(item_of(CMD_DONE, 2'd2, 48'h0, 16'd9800));                   // flow read error stops
    issue(item_of(CMD_START, ERR_NONE, 48'h0, 16'd0));
    issue(item_of(CMD_DONE, 2'd3, 48'h0, 16'd0));                      // flow request error stops
    issue(item_of(CMD_START, ERR_NONE, 48'h0, 16'd0));
    issue(item_of(CMD_DONE, ERR_NONE, 48'h0, 16'd0));
    issue(item_of(CMD_DONE, ERR_NONE, 48'hFFFFFF_123456, 16'd0));
    issue(item_of(CMD_DONE, 2'd2, 48'h0, 16'd0));                      // pressure read error stops
    issue(item_of(CMD_DONE, ERR_NACK, 48'h0, 16'd0));                  // completion while stopped

    // random phases: idling pattern per pair of blocks, new settings per block
    for (int unsigned blk = 0; blk < 6; blk++) begin
      drain();
      case (blk / 2)
        0: begin send_idle = 35; recv_idle = 70; end
        1: begin send_idle = 70; recv_idle = 35; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      load_settings(settings_for(blk));
      repeat (275) issue(random_item());
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sps_pkg.sv
rtl/sps_cfg_regs.sv
rtl/sps_step.sv
rtl/sensor_poll_sequencer.sv
tb/sensor_poll_sequencer_tb.sv
